@@ design/chip8_pkg.sv @@
// Shared types, codes and helpers of the CHIP-8 core.
package chip8_pkg;

    localparam int MEM_SIZE_DEF    = 4096;
    localparam int STACK_DEPTH_DEF = 16;
    localparam logic [11:0] START_RESET = 12'h200;

    // request codes
    localparam logic [2:0] REQ_STEP     = 3'd0;
    localparam logic [2:0] REQ_TICK     = 3'd1;
    localparam logic [2:0] REQ_KEY_DOWN = 3'd2;
    localparam logic [2:0] REQ_KEY_UP   = 3'd3;
    localparam logic [2:0] REQ_LOAD     = 3'd4;
    localparam logic [2:0] REQ_ROW      = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_WAIT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;

    // opcode groups (top nibble)
    localparam logic [3:0] G_SYS  = 4'h0;
    localparam logic [3:0] G_JP   = 4'h1;
    localparam logic [3:0] G_CALL = 4'h2;
    localparam logic [3:0] G_SE   = 4'h3;
    localparam logic [3:0] G_SNE  = 4'h4;
    localparam logic [3:0] G_SER  = 4'h5;
    localparam logic [3:0] G_LD   = 4'h6;
    localparam logic [3:0] G_ADD  = 4'h7;
    localparam logic [3:0] G_ALU  = 4'h8;
    localparam logic [3:0] G_SNER = 4'h9;
    localparam logic [3:0] G_LDI  = 4'hA;
    localparam logic [3:0] G_JPV  = 4'hB;
    localparam logic [3:0] G_RND  = 4'hC;
    localparam logic [3:0] G_DRW  = 4'hD;
    localparam logic [3:0] G_SKEY = 4'hE;
    localparam logic [3:0] G_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] EX_SKP  = 8'h9E;
    localparam logic [7:0] EX_SKNP = 8'hA1;

    localparam logic [7:0] FX_GET_DT = 8'h07;
    localparam logic [7:0] FX_KEY    = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    localparam logic [7:0] RND_WRAP = 8'hFF;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [3:0]  key_index;
        logic [7:0]  random_byte;
    } in_item_t;

    typedef struct packed {
        logic [11:0] pc_value;
        logic [1:0]  status;
        logic        sound_on;
        logic [63:0] row_data;
        logic        display_changed;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH_HI, S_FETCH_LO, S_CAPTURE, S_READ_Y, S_EXEC,
        S_RET, S_DRAW_RD, S_DRAW_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_RESULT
    } ctl_state_t;

    typedef enum logic [3:0] {
        UOP_NONE, UOP_CLEAR, UOP_ACCEPT, UOP_FETCH_HI, UOP_FETCH_LO, UOP_CAPTURE,
        UOP_READ_Y, UOP_EXEC, UOP_RET, UOP_DRAW_RD, UOP_DRAW_WR, UOP_BCD,
        UOP_STORE, UOP_LOAD_RD, UOP_LOAD_WR, UOP_RESULT
    } uop_t;

    typedef struct packed {
        logic        clear_done;
        logic        item_is_step;
        logic [15:0] opcode;
        logic        loop_last;
        logic        out_free;
    } dp_status_t;

    // decimal digit k (0 hundreds, 1 tens, 2 ones) of v
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] k);
        logic [7:0]  h;
        logic [7:0]  rem;
        logic [7:0]  t;
        logic [15:0] p;
        h   = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
        rem = (v >= 8'd200) ? v - 8'd200 : ((v >= 8'd100) ? v - 8'd100 : v);
        p   = 16'(rem) * 16'd205;
        t   = 8'(p >> 11);
        case (k)
            2'd0:    return h;
            2'd1:    return t;
            default: return rem - 8'(t * 8'd10);
        endcase
    endfunction

endpackage

@@ design/chip8_if.sv @@
// Handshake channels of the CHIP-8 core: request, result and configuration.
interface chip8_in_if import chip8_pkg::*;;
    logic     valid;
    logic     ready;
    in_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface chip8_out_if import chip8_pkg::*;;
    logic      valid;
    logic      ready;
    out_item_t item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface chip8_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] start_address;
    modport source (output valid, output start_address, input ready);
    modport sink   (input valid, input start_address, output ready);
endinterface

@@ design/chip8_ram.sv @@
// Generic single-port RAM with registered read.
module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

@@ design/chip8_ctrl.sv @@
// Sequencer of the CHIP-8 core: walks each item through its micro-operations.
module chip8_ctrl import chip8_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output uop_t       uop
);
    ctl_state_t state_reg, state_next;
    logic [3:0] grp;
    logic [7:0] nn;

    assign grp = status.opcode[15:12];
    assign nn  = status.opcode[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        uop        = UOP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                uop = UOP_CLEAR;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    uop        = UOP_ACCEPT;
                    state_next = status.item_is_step ? S_FETCH_HI : S_RESULT;
                end
            end
            S_FETCH_HI:
            begin
                uop        = UOP_FETCH_HI;
                state_next = S_FETCH_LO;
            end
            S_FETCH_LO:
            begin
                uop        = UOP_FETCH_LO;
                state_next = S_CAPTURE;
            end
            S_CAPTURE:
            begin
                uop        = UOP_CAPTURE;
                state_next = S_READ_Y;
            end
            S_READ_Y:
            begin
                uop        = UOP_READ_Y;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                uop        = UOP_EXEC;
                state_next = S_RESULT;
                if (status.opcode == OPC_RET)
                begin
                    state_next = S_RET;
                end
                else if (grp == G_DRW && status.opcode[3:0] != 4'd0)
                begin
                    state_next = S_DRAW_RD;
                end
                else if (grp == G_MISC && nn == FX_BCD)
                begin
                    state_next = S_BCD;
                end
                else if (grp == G_MISC && nn == FX_STORE)
                begin
                    state_next = S_STORE;
                end
                else if (grp == G_MISC && nn == FX_LOAD)
                begin
                    state_next = S_LOAD_RD;
                end
            end
            S_RET:
            begin
                uop        = UOP_RET;
                state_next = S_RESULT;
            end
            S_DRAW_RD:
            begin
                uop        = UOP_DRAW_RD;
                state_next = S_DRAW_WR;
            end
            S_DRAW_WR:
            begin
                uop        = UOP_DRAW_WR;
                state_next = status.loop_last ? S_RESULT : S_DRAW_RD;
            end
            S_BCD:
            begin
                uop = UOP_BCD;
                if (status.loop_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_STORE:
            begin
                uop = UOP_STORE;
                if (status.loop_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_LOAD_RD:
            begin
                uop        = UOP_LOAD_RD;
                state_next = S_LOAD_WR;
            end
            S_LOAD_WR:
            begin
                uop        = UOP_LOAD_WR;
                state_next = status.loop_last ? S_RESULT : S_LOAD_RD;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    uop        = UOP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_result_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && status.out_free) |=> state_reg == S_IDLE)
        else $error("result handed over but sequencer not idle");

    a_misc_short: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !status.item_is_step) |=> state_reg == S_RESULT)
        else $error("non-step item did not go straight to result");
endmodule

@@ design/chip8_dp.sv @@
// Datapath of the CHIP-8 core: machine state, memories, ALU and result register.
module chip8_dp import chip8_pkg::*; #(
    parameter int MEM_SIZE    = MEM_SIZE_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  uop_t        uop,
    output dp_status_t  status,
    input  in_item_t    in_item,
    input  logic        cfg_valid,
    input  logic [11:0] cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);
    localparam int AW  = $clog2(MEM_SIZE);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam logic [15:0] MS16 = 16'(MEM_SIZE);

    function automatic logic [AW-1:0] maddr(input logic [12:0] a);
        logic [15:0] r;
        r = {3'b0, a};
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (MS16 << k))
            begin
                r = r - (MS16 << k);
            end
        end
        return r[AW-1:0];
    endfunction

    function automatic logic [63:0] row_mask(input logic [7:0] b, input logic [5:0] sh);
        logic [127:0] w;
        w = {b, 56'b0, b, 56'b0} >> sh;
        return w[63:0];
    endfunction

    // architectural state
    logic [11:0]            pc_reg;
    logic [11:0]            i_reg;
    logic [7:0]             v_reg [16];
    logic [SPW-1:0]         sp_reg;
    logic [STACK_DEPTH-1:0] stk_valid_reg;
    logic [7:0]             dt_reg;
    logic [7:0]             st_reg;
    logic [15:0]            key_reg;
    logic [3:0]             rel_key_reg;
    logic                   rel_valid_reg;
    logic [63:0]            frame_reg [32];
    logic [AW-1:0]          clr_cnt_reg;
    logic [3:0]             cnt_reg;
    logic [2:0]             req_reg;
    logic [1:0]             status_reg;
    logic [63:0]            row_reg;
    logic                   chg_reg;
    logic                   out_valid_reg;

    // payload
    logic [15:0]            op_reg;
    logic [7:0]             vx_reg;
    logic [7:0]             vy_reg;
    logic [7:0]             rnd_reg;
    out_item_t              out_item_reg;

    logic [AW-1:0]          ram_addr;
    logic                   ram_we;
    logic [7:0]             ram_wdata;
    logic [7:0]             ram_rdata;
    logic [SPW-1:0]         stk_addr;
    logic                   stk_we;
    logic [11:0]            stk_rdata;

    logic [3:0]  grp, xi, yi, sub;
    logic [7:0]  nn;
    logic [11:0] nnn, pc_plus2, pc_skip;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [8:0]  sum9;
    logic [63:0] mask;
    logic [4:0]  draw_row;
    logic        out_free;

    assign grp      = op_reg[15:12];
    assign xi       = op_reg[11:8];
    assign yi       = op_reg[7:4];
    assign sub      = op_reg[3:0];
    assign nn       = op_reg[7:0];
    assign nnn      = op_reg[11:0];
    assign pc_plus2 = pc_reg + 12'd2;
    assign pc_skip  = pc_reg + 12'd4;
    assign sp_inc   = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec   = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sum9     = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign mask     = row_mask(ram_rdata, vx_reg[5:0]);
    assign draw_row = vy_reg[4:0] + {1'b0, cnt_reg};
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = '0;
        ram_addr  = maddr({1'b0, pc_reg});
        case (uop)
            UOP_CLEAR:
            begin
                ram_addr = clr_cnt_reg;
                ram_we   = 1'b1;
            end
            UOP_ACCEPT:
            begin
                ram_addr  = maddr({1'b0, in_item.address});
                ram_we    = (in_item.req_type == REQ_LOAD);
                ram_wdata = in_item.data_byte;
            end
            UOP_FETCH_LO:
            begin
                ram_addr = maddr({1'b0, pc_reg} + 13'd1);
            end
            UOP_DRAW_RD:
            begin
                ram_addr = maddr({1'b0, i_reg} + 13'(cnt_reg));
            end
            UOP_BCD:
            begin
                ram_addr  = maddr({1'b0, i_reg} + 13'(cnt_reg));
                ram_we    = 1'b1;
                ram_wdata = bcd_digit(vx_reg, cnt_reg[1:0]);
            end
            UOP_STORE:
            begin
                ram_addr  = maddr({1'b0, i_reg});
                ram_we    = 1'b1;
                ram_wdata = v_reg[cnt_reg];
            end
            UOP_LOAD_RD:
            begin
                ram_addr = maddr({1'b0, i_reg});
            end
            default:
            begin
                ram_addr = maddr({1'b0, pc_reg});
            end
        endcase
    end

    assign stk_we   = (uop == UOP_EXEC) && (grp == G_CALL);
    assign stk_addr = (grp == G_CALL) ? sp_reg : sp_dec;

    chip8_ram #(.WIDTH(8), .DEPTH(MEM_SIZE)) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    chip8_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (pc_plus2),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        status.clear_done   = (clr_cnt_reg == AW'(MEM_SIZE - 1));
        status.item_is_step = (in_item.req_type == REQ_STEP);
        status.opcode       = op_reg;
        status.out_free     = out_free;
        if (grp == G_DRW)
        begin
            status.loop_last = (cnt_reg == sub - 4'd1);
        end
        else if (nn == FX_BCD)
        begin
            status.loop_last = (cnt_reg == 4'd2);
        end
        else
        begin
            status.loop_last = (cnt_reg == xi);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= START_RESET;
            i_reg         <= '0;
            sp_reg        <= '0;
            stk_valid_reg <= '0;
            dt_reg        <= '0;
            st_reg        <= '0;
            key_reg       <= '0;
            rel_key_reg   <= '0;
            rel_valid_reg <= 1'b0;
            clr_cnt_reg   <= '0;
            cnt_reg       <= '0;
            req_reg       <= REQ_STEP;
            status_reg    <= ST_OK;
            row_reg       <= '0;
            chg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                v_reg[k] <= '0;
            end
            for (int k = 0; k < 32; k++)
            begin
                frame_reg[k] <= '0;
            end
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                pc_reg <= cfg_data;
            end
            case (uop)
                UOP_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                UOP_ACCEPT:
                begin
                    req_reg    <= in_item.req_type;
                    status_reg <= ST_OK;
                    chg_reg    <= 1'b0;
                    row_reg    <= '0;
                    case (in_item.req_type)
                        REQ_TICK:
                        begin
                            if (dt_reg != 8'd0) dt_reg <= dt_reg - 8'd1;
                            if (st_reg != 8'd0) st_reg <= st_reg - 8'd1;
                        end
                        REQ_KEY_DOWN:
                        begin
                            key_reg[in_item.key_index] <= 1'b1;
                        end
                        REQ_KEY_UP:
                        begin
                            key_reg[in_item.key_index] <= 1'b0;
                            rel_key_reg                <= in_item.key_index;
                            rel_valid_reg              <= 1'b1;
                        end
                        REQ_ROW:
                        begin
                            row_reg <= frame_reg[in_item.address[4:0]];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                UOP_EXEC:
                begin
                    pc_reg  <= pc_plus2;
                    cnt_reg <= '0;
                    case (grp)
                        G_SYS:
                        begin
                            if (op_reg == OPC_CLS)
                            begin
                                for (int k = 0; k < 32; k++)
                                begin
                                    frame_reg[k] <= '0;
                                end
                                chg_reg <= 1'b1;
                            end
                            else if (op_reg == OPC_RET)
                            begin
                                sp_reg <= sp_dec;
                            end
                        end
                        G_JP:   pc_reg <= nnn;
                        G_CALL:
                        begin
                            stk_valid_reg[sp_reg] <= 1'b1;
                            sp_reg                <= sp_inc;
                            pc_reg                <= nnn;
                        end
                        G_SE:   if (vx_reg == nn) pc_reg <= pc_skip;
                        G_SNE:  if (vx_reg != nn) pc_reg <= pc_skip;
                        G_SER:  if (vx_reg == vy_reg) pc_reg <= pc_skip;
                        G_SNER: if (vx_reg != vy_reg) pc_reg <= pc_skip;
                        G_LD:   v_reg[xi] <= nn;
                        G_ADD:  v_reg[xi] <= vx_reg + nn;
                        G_ALU:
                        begin
                            case (sub)
                                ALU_MOV: v_reg[xi] <= vy_reg;
                                ALU_OR:  v_reg[xi] <= vx_reg | vy_reg;
                                ALU_AND: v_reg[xi] <= vx_reg & vy_reg;
                                ALU_XOR: v_reg[xi] <= vx_reg ^ vy_reg;
                                ALU_ADD:
                                begin
                                    v_reg[15] <= {7'b0, sum9[8]};
                                    v_reg[xi] <= sum9[7:0];
                                end
                                ALU_SUB:
                                begin
                                    v_reg[15] <= {7'b0, vx_reg >= vy_reg};
                                    v_reg[xi] <= vx_reg - vy_reg;
                                end
                                ALU_SHR:
                                begin
                                    v_reg[15] <= {7'b0, vx_reg[0]};
                                    v_reg[xi] <= {1'b0, vx_reg[7:1]};
                                end
                                ALU_SUBN:
                                begin
                                    v_reg[15] <= {7'b0, vy_reg >= vx_reg};
                                    v_reg[xi] <= vy_reg - vx_reg;
                                end
                                ALU_SHL:
                                begin
                                    v_reg[15] <= {7'b0, vx_reg[7]};
                                    v_reg[xi] <= {vx_reg[6:0], 1'b0};
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        G_LDI:  i_reg <= nnn;
                        G_JPV:  pc_reg <= {4'b0, vy_reg} + nnn;
                        G_RND:  v_reg[xi] <= ((rnd_reg == RND_WRAP) ? 8'd0 : rnd_reg) & nn;
                        G_DRW:
                        begin
                            v_reg[15] <= '0;
                            chg_reg   <= 1'b1;
                        end
                        G_SKEY:
                        begin
                            if ((nn == EX_SKP && key_reg[vx_reg[3:0]])
                                || (nn == EX_SKNP && !key_reg[vx_reg[3:0]]))
                            begin
                                pc_reg <= pc_skip;
                            end
                        end
                        G_MISC:
                        begin
                            case (nn)
                                FX_GET_DT: v_reg[xi] <= dt_reg;
                                FX_KEY:
                                begin
                                    if (rel_valid_reg)
                                    begin
                                        v_reg[xi]     <= {4'b0, rel_key_reg};
                                        rel_valid_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        pc_reg     <= pc_reg;
                                        status_reg <= ST_WAIT;
                                    end
                                end
                                FX_SET_DT: dt_reg <= vx_reg;
                                FX_SET_ST: st_reg <= vx_reg;
                                FX_ADD_I:  i_reg  <= i_reg + {4'b0, vx_reg};
                                FX_FONT:   i_reg  <= {4'b0, vx_reg} + {2'b0, vx_reg, 2'b0};
                                FX_BCD, FX_STORE, FX_LOAD:
                                begin
                                end
                                default:   status_reg <= ST_ILLEGAL;
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase
                end
                UOP_RET:
                begin
                    pc_reg <= stk_valid_reg[sp_reg] ? stk_rdata : 12'd0;
                end
                UOP_DRAW_WR:
                begin
                    frame_reg[draw_row] <= frame_reg[draw_row] ^ mask;
                    if ((frame_reg[draw_row] & mask) != 64'd0)
                    begin
                        v_reg[15] <= 8'd1;
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                UOP_BCD:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
                UOP_STORE:
                begin
                    i_reg   <= i_reg + 12'd1;
                    cnt_reg <= cnt_reg + 4'd1;
                end
                UOP_LOAD_WR:
                begin
                    v_reg[cnt_reg] <= ram_rdata;
                    i_reg          <= i_reg + 12'd1;
                    cnt_reg        <= cnt_reg + 4'd1;
                end
                UOP_RESULT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (uop)
            UOP_ACCEPT:
            begin
                rnd_reg <= in_item.random_byte;
            end
            UOP_FETCH_LO:
            begin
                op_reg[15:8] <= ram_rdata;
            end
            UOP_CAPTURE:
            begin
                op_reg[7:0] <= ram_rdata;
                vx_reg      <= v_reg[op_reg[11:8]];
            end
            UOP_READ_Y:
            begin
                vy_reg <= (grp == G_JPV) ? v_reg[0] : v_reg[yi];
            end
            UOP_RESULT:
            begin
                out_item_reg.pc_value        <= pc_reg;
                out_item_reg.status          <= status_reg;
                out_item_reg.sound_on        <= (st_reg != 8'd0);
                out_item_reg.row_data        <= row_reg;
                out_item_reg.display_changed <= chg_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_status_step: assert property (@(posedge clk) disable iff (!rst_n)
        status_reg != ST_OK |-> req_reg == REQ_STEP)
        else $error("non-ok status on a non-step item");

    a_row_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg != 64'd0 |-> req_reg == REQ_ROW)
        else $error("row data on a non-read item");

    a_changed_step: assert property (@(posedge clk) disable iff (!rst_n)
        chg_reg |-> (req_reg == REQ_STEP && (grp == G_SYS || grp == G_DRW)))
        else $error("display change without clear or draw");
endmodule

@@ design/chip8_interpreter_core.sv @@
// CHIP-8 interpreter core: 4 KiB-class byte memory, V0..VF, I, PC, return
// stack, timers, keypad and a 64x32 framebuffer; one result per item.
// After reset the byte memory is swept to zero, one address per cycle,
// before the first item is taken (configuration is taken throughout).
// Items are handled one at a time by the sequencer: non-step items go
// from accept to result; an instruction steps through accept, fetch,
// register read, execute and result, plus a return step for 00EE and
// memory steps per row, digit or register for DXYN, FX33, FX55 and FX65,
// all bound by the single byte-memory port. The result sits in an output
// register, and the core waits there only while that register is still full.
module chip8_interpreter_core import chip8_pkg::*; #(
    parameter int MEM_SIZE    = MEM_SIZE_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    chip8_in_if.sink     req,
    chip8_out_if.source  rsp,
    chip8_cfg_if.sink    cfg
);
    uop_t       uop;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;
    out_item_t  out_item;

    chip8_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .status   (status),
        .uop      (uop)
    );

    chip8_dp #(
        .MEM_SIZE    (MEM_SIZE),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .uop       (uop),
        .status    (status),
        .in_item   (req.item),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.start_address),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .out_item  (out_item)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;
    assign rsp.item  = out_item;
    assign cfg.ready = 1'b1;
endmodule
